// ===== hdl/mrba_pkg.sv =====
// ----------------------------------------------------------------------------
// mrba_pkg
// Shared types and constants of the multi-resource bucket admission block:
// field widths, register indexes, opcodes and the channel word layouts.
// ----------------------------------------------------------------------------
package mrba_pkg;

   // lanes and widths fixed by the word layouts
   localparam int NUM_LANES = 4;
   localparam int NUM_TYPES = 4;
   localparam int AMT_W     = 16;
   localparam int CNT_W     = 16;
   localparam int FILL_W    = 17;
   localparam int IDX_W     = 3;
   localparam int SUM_W     = 19;
   localparam int LCNT_W    = 3;
   localparam int BIT_CNT_W = $clog2(AMT_W);

   // lanes at or beyond the supported type count are never offered
   localparam logic [NUM_LANES-1:0] TYPE_EN = (NUM_TYPES >= NUM_LANES) ?
      {NUM_LANES{1'b1}} : NUM_LANES'((1 << NUM_TYPES) - 1);

   // reset values and limits
   localparam logic [AMT_W-1:0]     CAP_RESET     = 16'hFFFF;
   localparam logic [NUM_LANES-1:0] OFFERED_RESET = 4'hF;
   localparam logic [CNT_W-1:0]     PLACED_MAX    = 16'hFFFF;
   localparam logic [FILL_W-1:0]    ONE_FIX       = 17'h10000;

   // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for x below 2^19
   localparam logic [17:0] RECIP3       = 18'd174763;
   localparam int          RECIP3_SHIFT = 19;

   // opcodes
   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_ADD   = 1'b1;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_CAP_RES0     = 3'd0;
   localparam logic [IDX_W-1:0] CSR_CAP_RES1     = 3'd1;
   localparam logic [IDX_W-1:0] CSR_CAP_RES2     = 3'd2;
   localparam logic [IDX_W-1:0] CSR_CAP_RES3     = 3'd3;
   localparam logic [IDX_W-1:0] CSR_OFFERED_MASK = 3'd4;

   // request word
   typedef struct packed {
      logic                 opcode;
      logic [NUM_LANES-1:0] needs_mask;
      logic [AMT_W-1:0]     demand_res0;
      logic [AMT_W-1:0]     demand_res1;
      logic [AMT_W-1:0]     demand_res2;
      logic [AMT_W-1:0]     demand_res3;
   } req_type;

   // response word
   typedef struct packed {
      logic              fits;
      logic              added;
      logic [AMT_W-1:0]  left_res0;
      logic [AMT_W-1:0]  left_res1;
      logic [AMT_W-1:0]  left_res2;
      logic [AMT_W-1:0]  left_res3;
      logic [CNT_W-1:0]  placed_count;
      logic [FILL_W-1:0] fill_rate;
   } rsp_type;

   // register write word
   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [AMT_W-1:0] value;
   } csr_type;

endpackage

// ===== hdl/mrba_stream_if.sv =====
// ----------------------------------------------------------------------------
// mrba_stream_if
// Valid/ready channel carrying one word of a configurable payload type.
// ----------------------------------------------------------------------------
interface mrba_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== hdl/multi_resource_bucket_admission.sv =====
// ----------------------------------------------------------------------------
// multi_resource_bucket_admission
// One bin of a multi-resource packer: fit check, guarded add, remaining
// amounts, placed count and fill rate.
// ----------------------------------------------------------------------------
// The block takes one request word at a time. The fit check and the usage
// update run bit-serially over all four resource lanes at once, one bit per
// cycle, then a decision state commits the usage. The fill rate then uses
// one radix-2 divider per lane, one quotient bit a cycle, and a mean state
// averages the ratios over the offered types. A new request is taken once
// the previous one has moved its response into the output register, even
// while that response still waits for rsp_ch.ready.
// Register writes are taken in any cycle and must only happen while idle.
module multi_resource_bucket_admission
   import mrba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   mrba_stream_if.sink   req_ch,
   mrba_stream_if.source rsp_ch,
   mrba_stream_if.sink   csr_ch
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SER  = 3'd1;
   localparam logic [2:0] ST_DEC  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_MEAN = 3'd4;

   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(AMT_W - 1);

   // configuration and bin state
   logic [AMT_W-1:0]     cap_ff     [NUM_LANES];
   logic [AMT_W-1:0]     cap_in     [NUM_LANES];
   logic [NUM_LANES-1:0] offered_ff, offered_in;
   logic [AMT_W-1:0]     usage_ff   [NUM_LANES];
   logic [AMT_W-1:0]     usage_in   [NUM_LANES];
   logic [CNT_W-1:0]     placed_ff, placed_in;

   // control
   logic [2:0]           state_ff, state_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 opcode_ff, opcode_in;
   logic [NUM_LANES-1:0] needs_ff, needs_in;

   // serial shift lines and chain bits per lane
   logic [AMT_W-1:0]     dem_sr_ff  [NUM_LANES];
   logic [AMT_W-1:0]     dem_sr_in  [NUM_LANES];
   logic [AMT_W-1:0]     cap_sr_ff  [NUM_LANES];
   logic [AMT_W-1:0]     cap_sr_in  [NUM_LANES];
   logic [AMT_W-1:0]     sum_sr_ff  [NUM_LANES];
   logic [AMT_W-1:0]     sum_sr_in  [NUM_LANES];
   logic [AMT_W-1:0]     lfs_sr_ff  [NUM_LANES];
   logic [AMT_W-1:0]     lfs_sr_in  [NUM_LANES];
   logic [AMT_W-1:0]     lfu_sr_ff  [NUM_LANES];
   logic [AMT_W-1:0]     lfu_sr_in  [NUM_LANES];
   logic [NUM_LANES-1:0] carry_ff, carry_in;
   logic [NUM_LANES-1:0] bws_ff, bws_in;
   logic [NUM_LANES-1:0] bwu_ff, bwu_in;
   logic [NUM_LANES-1:0] dnz_ff, dnz_in;

   // decision results and fill rate
   logic [AMT_W-1:0]     left_ff    [NUM_LANES];
   logic [AMT_W-1:0]     left_in    [NUM_LANES];
   logic                 fits_ff, fits_in;
   logic                 added_ff, added_in;
   logic [SUM_W-1:0]     rsum_ff, rsum_in;
   logic [LCNT_W-1:0]    ones_ff, ones_in;

   // response register
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic [NUM_LANES-1:0] lane_en;
   logic [AMT_W-1:0]     demand     [NUM_LANES];
   logic [NUM_LANES-1:0] u_bit, d_bit, c_bit;
   logic [NUM_LANES-1:0] s_bit, s_carry, ds_bit, ds_bw, du_bit, du_bw;
   logic [NUM_LANES-1:0] lane_fit;
   logic                 fits_now;
   logic                 commit;
   logic                 div_start;
   logic [AMT_W-1:0]     div_num    [NUM_LANES];
   logic [NUM_LANES-1:0] div_busy;
   logic [FILL_W-1:0]    ratio      [NUM_LANES];
   logic [SUM_W-1:0]     ratio_total;
   logic [LCNT_W-1:0]    lane_total;
   logic [35:0]          third_prod;
   logic [FILL_W-1:0]    mean;

   assign lane_en   = offered_ff & TYPE_EN;
   assign demand[0] = req_ch.data.demand_res0;
   assign demand[1] = req_ch.data.demand_res1;
   assign demand[2] = req_ch.data.demand_res2;
   assign demand[3] = req_ch.data.demand_res3;

   // one bit per lane: usage + demand, cap - sum, cap - usage
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         u_bit[i]   = usage_ff[i][0];
         d_bit[i]   = dem_sr_ff[i][0];
         c_bit[i]   = cap_sr_ff[i][0];
         s_bit[i]   = u_bit[i] ^ d_bit[i] ^ carry_ff[i];
         s_carry[i] = (u_bit[i] & d_bit[i]) | (u_bit[i] & carry_ff[i]) |
                      (d_bit[i] & carry_ff[i]);
         ds_bit[i]  = c_bit[i] ^ s_bit[i] ^ bws_ff[i];
         ds_bw[i]   = (~c_bit[i] & s_bit[i]) | (~c_bit[i] & bws_ff[i]) |
                      (s_bit[i] & bws_ff[i]);
         du_bit[i]  = c_bit[i] ^ u_bit[i] ^ bwu_ff[i];
         du_bw[i]   = (~c_bit[i] & u_bit[i]) | (~c_bit[i] & bwu_ff[i]) |
                      (u_bit[i] & bwu_ff[i]);
      end
   end

   // fit per lane once the serial pass is done
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_fit[i] = !needs_ff[i] ||
                       (lane_en[i] && (!dnz_ff[i] || (!bws_ff[i] && !carry_ff[i])));
      end
   end

   assign fits_now  = &lane_fit;
   assign commit    = (opcode_ff == OP_ADD) && fits_now;
   assign div_start = state_ff == ST_DEC;

   // per-lane ratio dividers, fed the usage after the commit
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_div
      assign div_num[g] = commit ? sum_sr_ff[g] : usage_ff[g];

      mrba_div u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .num   (div_num[g]),
         .den   (cap_ff[g]),
         .busy  (div_busy[g]),
         .ratio (ratio[g])
      );
   end

   // sum of ratios and count over the offered lanes
   always_comb begin
      ratio_total = '0;
      lane_total  = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (lane_en[i]) begin
            ratio_total = ratio_total + SUM_W'(ratio[i]);
            lane_total  = lane_total + 1'b1;
         end
      end
   end

   // mean over the offered lanes
   assign third_prod = rsum_ff[17:0] * RECIP3;

   always_comb begin
      case (ones_ff)
         3'd1:    mean = rsum_ff[FILL_W-1:0];
         3'd2:    mean = rsum_ff[FILL_W:1];
         3'd3:    mean = third_prod[RECIP3_SHIFT+FILL_W-1:RECIP3_SHIFT];
         3'd4:    mean = rsum_ff[FILL_W+1:2];
         default: mean = '0;
      endcase
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      opcode_in    = opcode_ff;
      needs_in     = needs_ff;
      placed_in    = placed_ff;
      offered_in   = offered_ff;
      carry_in     = carry_ff;
      bws_in       = bws_ff;
      bwu_in       = bwu_ff;
      dnz_in       = dnz_ff;
      fits_in      = fits_ff;
      added_in     = added_ff;
      rsum_in      = rsum_ff;
      ones_in      = ones_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         cap_in[i]    = cap_ff[i];
         usage_in[i]  = usage_ff[i];
         dem_sr_in[i] = dem_sr_ff[i];
         cap_sr_in[i] = cap_sr_ff[i];
         sum_sr_in[i] = sum_sr_ff[i];
         lfs_sr_in[i] = lfs_sr_ff[i];
         lfu_sr_in[i] = lfu_sr_ff[i];
         left_in[i]   = left_ff[i];
      end

      // response taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // capture the request, clear the bit chains
            if (req_ch.valid) begin
               opcode_in  = req_ch.data.opcode;
               needs_in   = req_ch.data.needs_mask;
               bit_cnt_in = '0;
               carry_in   = '0;
               bws_in     = '0;
               bwu_in     = '0;
               dnz_in     = '0;
               for (int i = 0; i < NUM_LANES; i++) begin
                  dem_sr_in[i] = req_ch.data.needs_mask[i] ? demand[i] : '0;
                  cap_sr_in[i] = cap_ff[i];
               end
               state_in = ST_SER;
            end
         end
         ST_SER: begin
            // one bit per lane, usage rotates back to itself
            for (int i = 0; i < NUM_LANES; i++) begin
               usage_in[i]  = {u_bit[i], usage_ff[i][AMT_W-1:1]};
               dem_sr_in[i] = {1'b0, dem_sr_ff[i][AMT_W-1:1]};
               cap_sr_in[i] = {1'b0, cap_sr_ff[i][AMT_W-1:1]};
               sum_sr_in[i] = {s_bit[i], sum_sr_ff[i][AMT_W-1:1]};
               lfs_sr_in[i] = {ds_bit[i], lfs_sr_ff[i][AMT_W-1:1]};
               lfu_sr_in[i] = {du_bit[i], lfu_sr_ff[i][AMT_W-1:1]};
            end
            carry_in   = s_carry;
            bws_in     = ds_bw;
            bwu_in     = du_bw;
            dnz_in     = dnz_ff | d_bit;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_LAST) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            // commit and pick the remaining amounts
            fits_in  = fits_now;
            added_in = commit;
            if (commit && (placed_ff != PLACED_MAX)) begin
               placed_in = placed_ff + 1'b1;
            end
            for (int i = 0; i < NUM_LANES; i++) begin
               if (commit) begin
                  usage_in[i] = sum_sr_ff[i];
               end
               if (!lane_en[i]) begin
                  left_in[i] = '0;
               end else if (commit) begin
                  left_in[i] = (bws_ff[i] || carry_ff[i]) ? '0 : lfs_sr_ff[i];
               end else begin
                  left_in[i] = bwu_ff[i] ? '0 : lfu_sr_ff[i];
               end
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // wait for all dividers, then total the ratios
            if (div_busy == '0) begin
               rsum_in  = ratio_total;
               ones_in  = lane_total;
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_data_in.fits         = fits_ff;
               rsp_data_in.added        = added_ff;
               rsp_data_in.left_res0    = left_ff[0];
               rsp_data_in.left_res1    = left_ff[1];
               rsp_data_in.left_res2    = left_ff[2];
               rsp_data_in.left_res3    = left_ff[3];
               rsp_data_in.placed_count = placed_ff;
               rsp_data_in.fill_rate    = mean;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes
      if (csr_ch.valid) begin
         case (csr_ch.data.index)
            CSR_CAP_RES0:     cap_in[0]  = csr_ch.data.value;
            CSR_CAP_RES1:     cap_in[1]  = csr_ch.data.value;
            CSR_CAP_RES2:     cap_in[2]  = csr_ch.data.value;
            CSR_CAP_RES3:     cap_in[3]  = csr_ch.data.value;
            CSR_OFFERED_MASK: offered_in = csr_ch.data.value[NUM_LANES-1:0];
            default:          offered_in = offered_ff;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         offered_ff   <= OFFERED_RESET;
         placed_ff    <= '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            cap_ff[i]   <= CAP_RESET;
            usage_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         offered_ff   <= offered_in;
         placed_ff    <= placed_in;
         for (int i = 0; i < NUM_LANES; i++) begin
            cap_ff[i]   <= cap_in[i];
            usage_ff[i] <= usage_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      opcode_ff   <= opcode_in;
      needs_ff    <= needs_in;
      carry_ff    <= carry_in;
      bws_ff      <= bws_in;
      bwu_ff      <= bwu_in;
      dnz_ff      <= dnz_in;
      fits_ff     <= fits_in;
      added_ff    <= added_in;
      rsum_ff     <= rsum_in;
      ones_ff     <= ones_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < NUM_LANES; i++) begin
         dem_sr_ff[i] <= dem_sr_in[i];
         cap_sr_ff[i] <= cap_sr_in[i];
         sum_sr_ff[i] <= sum_sr_in[i];
         lfs_sr_ff[i] <= lfs_sr_in[i];
         lfu_sr_ff[i] <= lfu_sr_in[i];
         left_ff[i]   <= left_in[i];
      end
   end

   // channel outputs
   assign req_ch.ready = state_ff == ST_IDLE;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

// ===== hdl/mrba_div.sv =====
// ----------------------------------------------------------------------------
// mrba_div
// Radix-2 restoring divider for one lane: ratio = usage * 2^16 / capacity,
// clamped to 1.0, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrba_div
   import mrba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [AMT_W-1:0]  num,
   input  logic [AMT_W-1:0]  den,
   output logic              busy,
   output logic [FILL_W-1:0] ratio
);

   localparam logic [BIT_CNT_W-1:0] STEP_LAST = BIT_CNT_W'(AMT_W - 1);

   logic                 busy_ff, busy_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [AMT_W-1:0]     rem_ff, rem_in;
   logic [AMT_W-1:0]     quo_ff, quo_in;
   logic                 full_ff, full_in;

   logic [AMT_W:0]       rem_dbl;
   logic [AMT_W:0]       rem_sub;
   logic                 take;
   logic                 num_zero;

   // trial subtract of the doubled remainder
   assign rem_dbl  = {rem_ff, 1'b0};
   assign rem_sub  = rem_dbl - {1'b0, den};
   assign take     = rem_dbl >= {1'b0, den};
   assign num_zero = num == '0;

   // start, iterate, stop
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      full_in = full_ff;
      if (start) begin
         // zero usage gives zero, usage at or above capacity clamps to one
         full_in = !num_zero && (num >= den);
         busy_in = !num_zero && (num < den);
         rem_in  = num;
         quo_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = take ? rem_sub[AMT_W-1:0] : rem_dbl[AMT_W-1:0];
         quo_in = {quo_ff[AMT_W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         full_ff <= 1'b0;
         quo_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         full_ff <= full_in;
         quo_ff  <= quo_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
   end

   assign busy  = busy_ff;
   assign ratio = full_ff ? ONE_FIX : {1'b0, quo_ff};

endmodule
